// File: hdl/plb_pkg.sv
// ----------------------------------------------------------------------------
// plb_pkg: shared types and constants for the price ladder best-level block
// Sizes, operation and status codes, bit search helpers.
// ----------------------------------------------------------------------------
package plb_pkg;

  localparam int MAX_SLOTS = 1024;
  localparam int WORD_BITS = 64;
  localparam int NWORDS    = MAX_SLOTS / WORD_BITS;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W     = SLOT_W + 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int WADDR_W   = $clog2(NWORDS);
  localparam int PRICE_W   = 48;
  localparam int TS_W      = 20;
  localparam int DCNT_W    = $clog2(PRICE_W + 1);

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [1:0] {
    KIND_ACTIVATE = 2'd0,
    KIND_REMOVE   = 2'd1,
    KIND_BEST     = 2'd2,
    KIND_LOOKUP   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_OFF  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CFG_SIDE  = 3'd0,
    CFG_TICK  = 3'd1,
    CFG_BASE  = 3'd2,
    CFG_HEAD  = 3'd3,
    CFG_SLOTS = 3'd4
  } cfg_idx_e;

  // position of the lowest set bit (0 if none)
  function automatic logic [BIT_W-1:0] lowest_set(input word_t w);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) pos = BIT_W'(i);
    end
    return pos;
  endfunction

  // position of the highest set bit (0 if none)
  function automatic logic [BIT_W-1:0] highest_set(input word_t w);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (w[i]) pos = BIT_W'(i);
    end
    return pos;
  endfunction

endpackage

// File: hdl/plb_div.sv
// ----------------------------------------------------------------------------
// plb_div: bit-serial unsigned divider
// Restoring division, one quotient bit per cycle, quotient and remainder.
// ----------------------------------------------------------------------------
module plb_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [plb_pkg::PRICE_W-1:0]  dividend_i,
  input  logic [plb_pkg::TS_W-1:0]     divisor_i,
  output logic                         done_o,
  output logic [plb_pkg::PRICE_W-1:0]  quot_o,
  output logic [plb_pkg::TS_W-1:0]     rem_o
);
  import plb_pkg::*;

  logic [PRICE_W-1:0] q_q, q_d;
  logic [TS_W-1:0]    r_q, r_d;
  logic [TS_W-1:0]    d_q, d_d;
  logic [DCNT_W-1:0]  cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [TS_W:0]      sh;
  logic [TS_W+1:0]    diff;

  always_comb begin
    sh     = {r_q, q_q[PRICE_W-1]};
    diff   = {1'b0, sh} - {2'b00, d_q};
    q_d    = q_q;
    r_d    = r_q;
    d_d    = d_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      q_d    = dividend_i;
      r_d    = '0;
      d_d    = divisor_i;
      cnt_d  = DCNT_W'(PRICE_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[TS_W+1]) begin
        r_d = diff[TS_W-1:0];
        q_d = {q_q[PRICE_W-2:0], 1'b1};
      end else begin
        r_d = sh[TS_W-1:0];
        q_d = {q_q[PRICE_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - DCNT_W'(1);
      if (cnt_q == DCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
    d_q <= d_d;
  end

  assign done_o = done_q;
  assign quot_o = q_q;
  assign rem_o  = r_q;

endmodule

// File: hdl/plb_bitmap_ram.sv
// ----------------------------------------------------------------------------
// plb_bitmap_ram: occupancy bitmap store
// One write and one read port, registered read, per-word valid bits.
// ----------------------------------------------------------------------------
module plb_bitmap_ram (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          we_i,
  input  logic [plb_pkg::WADDR_W-1:0]   waddr_i,
  input  plb_pkg::word_t                wdata_i,
  input  logic                          re_i,
  input  logic [plb_pkg::WADDR_W-1:0]   raddr_i,
  output plb_pkg::word_t                rdata_o
);
  import plb_pkg::*;

  word_t             mem_q [NWORDS];
  logic [NWORDS-1:0] valid_q;
  word_t             rword_q;
  logic              rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rword_q <= mem_q[raddr_i];
  end

  // never-written words read as empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rvld_q  <= 1'b0;
    end else begin
      if (we_i) valid_q[waddr_i] <= 1'b1;
      if (re_i) rvld_q <= valid_q[raddr_i];
    end
  end

  assign rdata_o = rvld_q ? rword_q : '0;

endmodule

// File: hdl/price_ladder_bitmap_best_level.sv
// ----------------------------------------------------------------------------
// price_ladder_bitmap_best_level: ring-ordered price ladder with best search
// Occupancy bitmap in a 16 x 64 memory; activate, remove, lookup, find best.
// ----------------------------------------------------------------------------
// One item at a time. Every item on an enabled ladder first reduces the head slot
// modulo the slots in use on the shared 48-step serial divider. Activate, remove
// and lookup then divide the price by the tick size on the same unit (skipped
// when the tick size is 0); if the price lands in the ladder they read one bitmap
// word, which activate and remove (the latter only for an empty level) write back.
// Find best scans the bitmap one word at a time (read, then evaluate), over at
// most 17 words. A disabled ladder goes straight to its result. A new item is taken
// while the last result still waits at the output.
// ----------------------------------------------------------------------------
module price_ladder_bitmap_best_level (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i,
  // input items
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [55:0] s_axis_tdata_i,   // [47:0] price_ticks, [48] level_empty
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] kind
  // result items
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [9:0] slot_index, [57:10] ladder_tick
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);
  import plb_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_HMOD     = 12'b0000_0000_0010,
    S_PDIV     = 12'b0000_0000_0100,
    S_CHECK    = 12'b0000_0000_1000,
    S_ADDR     = 12'b0000_0001_0000,
    S_RMW      = 12'b0000_0010_0000,
    S_SCAN_SET = 12'b0000_0100_0000,
    S_SCAN_RD  = 12'b0000_1000_0000,
    S_SCAN_EV  = 12'b0001_0000_0000,
    S_SCAN_HIT = 12'b0010_0000_0000,
    S_TICK     = 12'b0100_0000_0000,
    S_FINISH   = 12'b1000_0000_0000
  } state_e;

  // configuration registers
  logic               side_q;
  logic [TS_W-1:0]    ts_q;
  logic [PRICE_W-1:0] base_q;
  logic [SLOT_W-1:0]  headcfg_q;
  logic [CNT_W-1:0]   slots_q;

  state_e             state_q, state_d;
  kind_e              kind_q, kind_d;
  logic [PRICE_W-1:0] price_q, price_d;
  logic               empty_q, empty_d;
  logic [SLOT_W-1:0]  head_q, head_d;
  logic [PRICE_W:0]   tick_q, tick_d;
  logic [SLOT_W-1:0]  off_q, off_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic               pass_q, pass_d;
  logic [CNT_W-1:0]   lo_q, lo_d, hi_q, hi_d;
  logic [WADDR_W-1:0] wcur_q, wcur_d, wlast_q, wlast_d;
  status_e            rstat_q, rstat_d;
  logic [PRICE_W-1:0] rtick_q, rtick_d;
  logic [SLOT_W-1:0]  rslot_q, rslot_d;

  logic               mvalid_q, mvalid_d;
  status_e            mstat_q;
  logic [PRICE_W-1:0] mtick_q;
  logic [SLOT_W-1:0]  mslot_q;
  logic               mload;

  logic [CNT_W-1:0]   n_eff;
  logic               asc;

  // divider hookup
  logic               div_start;
  logic [PRICE_W-1:0] div_dividend;
  logic [TS_W-1:0]    div_divisor;
  logic               div_done;
  logic [PRICE_W-1:0] div_quot;
  logic [TS_W-1:0]    div_rem;

  // memory hookup
  logic               mem_we, mem_re;
  logic [WADDR_W-1:0] mem_waddr, mem_raddr;
  word_t              mem_wdata, mem_rdata;

  // temporaries
  logic [PRICE_W+1:0] off_full;
  logic [CNT_W-1:0]   sum;
  logic [CNT_W-1:0]   last_slot;
  word_t              bitmask, scanmask, masked;
  logic [SLOT_W-1:0]  idx;
  logic [CNT_W-1:0]   rlo, rhi;

  assign n_eff = (slots_q > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : slots_q;
  assign asc   = side_q;

  // configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q    <= 1'b0;
      ts_q      <= TS_W'(1);
      base_q    <= '0;
      headcfg_q <= '0;
      slots_q   <= CNT_W'(MAX_SLOTS);
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SIDE:  side_q    <= cfg_data_i[0];
        CFG_TICK:  ts_q      <= cfg_data_i[TS_W-1:0];
        CFG_BASE:  base_q    <= cfg_data_i[PRICE_W-1:0];
        CFG_HEAD:  headcfg_q <= cfg_data_i[SLOT_W-1:0];
        CFG_SLOTS: slots_q   <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  plb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  plb_bitmap_ram u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign mload = (state_q == S_FINISH) && (!mvalid_q || m_axis_tready_i);

  // scan region of the current pass: sell walks [head,n) then [0,head) upward,
  // buy walks [0,head) then [head,n) downward
  always_comb begin
    if (pass_q == side_q) begin
      rlo = '0;
      rhi = {1'b0, head_q};
    end else begin
      rlo = {1'b0, head_q};
      rhi = n_eff;
    end
  end

  // slot window of the word being evaluated
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      idx = {wcur_q, BIT_W'(i)};
      scanmask[i] = ({1'b0, idx} >= lo_q) && ({1'b0, idx} < hi_q);
    end
    masked = mem_rdata & scanmask;
  end

  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    price_d      = price_q;
    empty_d      = empty_q;
    head_d       = head_q;
    tick_d       = tick_q;
    off_d        = off_q;
    slot_d       = slot_q;
    pass_d       = pass_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    wcur_d       = wcur_q;
    wlast_d      = wlast_q;
    rstat_d      = rstat_q;
    rtick_d      = rtick_q;
    rslot_d      = rslot_q;
    div_start    = 1'b0;
    div_dividend = PRICE_W'(headcfg_q);
    div_divisor  = TS_W'(n_eff);
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = slot_q[SLOT_W-1:BIT_W];
    mem_raddr    = slot_q[SLOT_W-1:BIT_W];
    bitmask      = word_t'(1) << slot_q[BIT_W-1:0];
    mem_wdata    = mem_rdata;
    off_full     = {{2{tick_q[PRICE_W]}}, tick_q[PRICE_W-1:0]}
                   - {{2{base_q[PRICE_W-1]}}, base_q};
    sum          = {1'b0, head_q} + {1'b0, off_q};
    last_slot    = rhi - CNT_W'(1);

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          kind_d  = kind_e'(s_axis_tuser_i);
          price_d = s_axis_tdata_i[PRICE_W-1:0];
          empty_d = s_axis_tdata_i[PRICE_W];
          if (n_eff == '0) begin
            rstat_d = ST_OFF;
            rtick_d = '0;
            rslot_d = '0;
            state_d = S_FINISH;
          end else begin
            div_start = 1'b1;
            state_d   = S_HMOD;
          end
        end
      end
      S_HMOD: begin
        if (div_done) begin
          head_d = div_rem[SLOT_W-1:0];
          pass_d = 1'b0;
          if (kind_q == KIND_BEST) begin
            state_d = S_SCAN_SET;
          end else if (ts_q == '0) begin
            tick_d  = {price_q[PRICE_W-1], price_q};
            state_d = S_CHECK;
          end else begin
            div_start    = 1'b1;
            div_dividend = price_q[PRICE_W-1] ? (~price_q + PRICE_W'(1)) : price_q;
            div_divisor  = ts_q;
            state_d      = S_PDIV;
          end
        end
      end
      S_PDIV: begin
        if (div_done) begin
          // truncation toward zero: negate the magnitude quotient
          tick_d  = price_q[PRICE_W-1] ? (~{1'b0, div_quot} + (PRICE_W+1)'(1))
                                       : {1'b0, div_quot};
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!off_full[PRICE_W+1] &&
            (off_full[PRICE_W:0] < (PRICE_W+1)'(n_eff))) begin
          off_d   = off_full[SLOT_W-1:0];
          state_d = S_ADDR;
        end else begin
          rstat_d = ST_NONE;
          rtick_d = '0;
          rslot_d = '0;
          state_d = S_FINISH;
        end
      end
      S_ADDR: begin
        slot_d  = (sum >= n_eff) ? SLOT_W'(sum - n_eff) : sum[SLOT_W-1:0];
        state_d = S_RMW;
      end
      S_RMW: begin
        // slot_q valid since S_ADDR; read issued here, data back next cycle
        mem_re  = 1'b1;
        state_d = S_TICK;
        rslot_d = slot_q;
        rstat_d = ST_OK;
      end
      S_TICK: begin
        // word read in S_RMW (addressed ops) is at the memory output now
        if (kind_q == KIND_ACTIVATE) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata | bitmask;
        end else if (kind_q == KIND_REMOVE) begin
          mem_we    = empty_q;
          mem_wdata = mem_rdata & ~bitmask;
        end else if (kind_q == KIND_LOOKUP) begin
          rstat_d = ((mem_rdata & bitmask) != '0) ? ST_OK : ST_NONE;
        end
        rtick_d = base_q + PRICE_W'(off_q);
        state_d = S_FINISH;
      end
      S_SCAN_SET: begin
        if (rlo == rhi) begin
          if (pass_q) begin
            rstat_d = ST_NONE;
            rtick_d = '0;
            rslot_d = '0;
            state_d = S_FINISH;
          end else begin
            pass_d = 1'b1;
          end
        end else begin
          lo_d    = rlo;
          hi_d    = rhi;
          wcur_d  = asc ? rlo[SLOT_W-1:BIT_W] : last_slot[SLOT_W-1:BIT_W];
          wlast_d = asc ? last_slot[SLOT_W-1:BIT_W] : rlo[SLOT_W-1:BIT_W];
          state_d = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        mem_re    = 1'b1;
        mem_raddr = wcur_q;
        state_d   = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        if (masked != '0) begin
          slot_d  = {wcur_q, asc ? lowest_set(masked) : highest_set(masked)};
          state_d = S_SCAN_HIT;
        end else if (wcur_q == wlast_q) begin
          if (pass_q) begin
            rstat_d = ST_NONE;
            rtick_d = '0;
            rslot_d = '0;
            state_d = S_FINISH;
          end else begin
            pass_d  = 1'b1;
            state_d = S_SCAN_SET;
          end
        end else begin
          wcur_d  = asc ? (wcur_q + WADDR_W'(1)) : (wcur_q - WADDR_W'(1));
          state_d = S_SCAN_RD;
        end
      end
      S_SCAN_HIT: begin
        // ring offset of the found slot from the head
        off_d   = SLOT_W'({1'b0, slot_q} + ((slot_q >= head_q) ? '0 : n_eff)
                          - {1'b0, head_q});
        rslot_d = slot_q;
        rstat_d = ST_OK;
        kind_d  = KIND_BEST;
        state_d = S_TICK;
      end
      S_FINISH: begin
        if (!mvalid_q || m_axis_tready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      mvalid_q <= mvalid_d;
    end
  end

  always_comb begin
    mvalid_d = mvalid_q;
    if (mload) mvalid_d = 1'b1;
    else if (m_axis_tready_i) mvalid_d = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    price_q <= price_d;
    empty_q <= empty_d;
    head_q  <= head_d;
    tick_q  <= tick_d;
    off_q   <= off_d;
    slot_q  <= slot_d;
    pass_q  <= pass_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    wcur_q  <= wcur_d;
    wlast_q <= wlast_d;
    rstat_q <= rstat_d;
    rtick_q <= rtick_d;
    rslot_q <= rslot_d;
    if (mload) begin
      mstat_q <= rstat_q;
      mtick_q <= rtick_q;
      mslot_q <= rslot_q;
    end
  end

  assign m_axis_tvalid_o = mvalid_q;
  assign m_axis_tuser_o  = mstat_q;
  assign m_axis_tdata_o  = {6'b0, mtick_q, mslot_q};

`ifndef SYNTHESIS
  a_div_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_HMOD) || (state_q == S_PDIV))
    else $error("divider finished outside a divide wait");

  a_off_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mvalid_q && (mstat_q == ST_OFF)) |-> (mslot_q == '0) && (mtick_q == '0))
    else $error("disabled ladder result carries a slot or tick");

  a_slot_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mvalid_q && (mstat_q == ST_OK)) |-> ({1'b0, mslot_q} < n_eff))
    else $error("reported slot beyond slots in use");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(mvalid_q) |-> $past(state_q == S_FINISH))
    else $error("result raised outside finish");

  a_write_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> !mem_re && (state_q == S_TICK) && (kind_q != KIND_BEST))
    else $error("bitmap write outside read-modify-write");
`endif

endmodule

// File: sim/price_ladder_bitmap_best_level_checker.sv
// ----------------------------------------------------------------------------
// price_ladder_bitmap_best_level_checker: result checker for the ladder
// Watches the config, input and result channels, keeps its own bitmap and
// register copies, predicts one result per input item and compares it.
// ----------------------------------------------------------------------------
module price_ladder_bitmap_best_level_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [55:0] in_data_i,
  input  logic [1:0]  in_user_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [63:0] out_data_i,
  input  logic [1:0]  out_user_i,
  output int          mismatches_o,
  output int          pending_o,
  output int          results_o
);
  import plb_pkg::*;

  typedef struct packed {
    status_e            status;
    logic [SLOT_W-1:0]  slot;
    logic [PRICE_W-1:0] tick;
  } ladder_result_t;

  logic [MAX_SLOTS-1:0] occupied;
  logic                 sell_side;
  logic [TS_W-1:0]      tick_size;
  logic [PRICE_W-1:0]   base_tick;
  logic [SLOT_W-1:0]    head_slot;
  logic [CNT_W-1:0]     slots_in_use;

  ladder_result_t expected_q[$];

  assign pending_o = expected_q.size();

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0h want %0h (result %0d)", what, got, want, results_o);
    mismatches_o++;
  endtask

  function automatic longint ring_tick(input longint s, input longint head, input longint n);
    return longint'(signed'(base_tick)) + (s + n - head) % n;
  endfunction

  // predicts the result and updates the bitmap copy
  task automatic predict_ladder_op(input kind_e kind, input logic [47:0] price,
                                   input logic empty);
    ladder_result_t r;
    longint n, head, s, tk, off;
    r = '{status: ST_OK, slot: '0, tick: '0};
    n = (slots_in_use > MAX_SLOTS) ? MAX_SLOTS : slots_in_use;
    if (n == 0) begin
      r.status = ST_OFF;
    end else begin
      head = head_slot % n;
      if (kind == KIND_BEST) begin
        r.status = ST_NONE;
        for (longint k = 0; k < n; k++) begin
          s = sell_side ? (head + k) % n : (head + n - 1 - k) % n;
          if (occupied[s]) begin
            r.status = ST_OK;
            r.slot = SLOT_W'(s);
            r.tick = PRICE_W'(ring_tick(s, head, n));
            break;
          end
        end
      end else begin
        tk = longint'(signed'(price));
        if (tick_size != 0) tk = tk / longint'(tick_size);
        off = tk - longint'(signed'(base_tick));
        if (off < 0 || off >= n) begin
          r.status = ST_NONE;
        end else begin
          s = (head + off) % n;
          r.slot = SLOT_W'(s);
          r.tick = PRICE_W'(ring_tick(s, head, n));
          case (kind)
            KIND_ACTIVATE: occupied[s] = 1'b1;
            KIND_REMOVE:   if (empty) occupied[s] = 1'b0;
            default:       if (!occupied[s]) r.status = ST_NONE;
          endcase
        end
      end
    end
    expected_q.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ladder_result_t want;
    if (!rst_ni) begin
      occupied     = '0;
      sell_side    = 1'b0;
      tick_size    = TS_W'(1);
      base_tick    = '0;
      head_slot    = '0;
      slots_in_use = CNT_W'(MAX_SLOTS);
      expected_q.delete();
      mismatches_o = 0;
      results_o    = 0;
    end else begin
      // result first: a new item is taken while the old result still waits
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", out_data_i, 0);
        end else begin
          want = expected_q.pop_front();
          if (out_user_i != want.status)
            report_mismatch("status", out_user_i, want.status);
          if (out_data_i[9:0] != want.slot)
            report_mismatch("slot_index", out_data_i[9:0], want.slot);
          if (out_data_i[57:10] != want.tick)
            report_mismatch("ladder_tick", out_data_i[57:10], want.tick);
        end
        results_o++;
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_SIDE:  sell_side    = cfg_data_i[0];
          CFG_TICK:  tick_size    = cfg_data_i[TS_W-1:0];
          CFG_BASE:  base_tick    = cfg_data_i;
          CFG_HEAD:  head_slot    = cfg_data_i[SLOT_W-1:0];
          CFG_SLOTS: slots_in_use = cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        predict_ladder_op(kind_e'(in_user_i), in_data_i[47:0], in_data_i[48]);
    end
  end

endmodule

// File: sim/price_ladder_bitmap_best_level_test.sv
// ----------------------------------------------------------------------------
// price_ladder_bitmap_best_level_test: stimulus top for the ladder block
// Directed corner items, then phased random traffic over several ladder
// settings with varied idling; the checker reports the verdict count.
// ----------------------------------------------------------------------------
module price_ladder_bitmap_best_level_test;
  import plb_pkg::*;

  localparam int WATCHDOG = 20000;   // idle cycles

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [47:0] cfg_data_i = '0;
  logic        s_valid = 1'b0;
  logic [55:0] s_data = '0;   // [47:0] price_ticks, [48] level_empty
  logic [1:0]  s_user = '0;   // [1:0] kind
  logic        m_ready = 1'b0;
  logic        cfg_ready_o, s_ready, m_valid;
  logic [63:0] m_data;        // [9:0] slot_index, [57:10] ladder_tick
  logic [1:0]  m_user;        // [1:0] status

  int mismatches, pending, results;
  int send_idle_pct, recv_stall_pct;
  int idle_count = 0;

  // current ladder setting, kept here to aim prices into range
  logic [19:0] cur_tick;
  longint      cur_base;
  int          cur_slots;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  price_ladder_bitmap_best_level u_dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tuser_i(s_user),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data), .m_axis_tuser_o(m_user)
  );

  price_ladder_bitmap_best_level_checker u_check (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i(s_valid), .in_ready_i(s_ready), .in_data_i(s_data), .in_user_i(s_user),
    .out_valid_i(m_valid), .out_ready_i(m_ready), .out_data_i(m_data),
    .out_user_i(m_user),
    .mismatches_o(mismatches), .pending_o(pending), .results_o(results)
  );

  // receiver: stalls at the phase's rate
  always @(posedge clk_i) begin
    m_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog: cycles with nothing accepted anywhere
  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid_i && cfg_ready_o))
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count > WATCHDOG) begin
      $display("watchdog expired, %0d results outstanding", pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // valid stays up after the write; set_ladder drops it after the last one
  task automatic write_reg(input cfg_idx_e idx, input logic [47:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // stops the input, waits for every outstanding result plus a quiet margin
  task automatic drain;
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic set_ladder(input logic side, input logic [19:0] tsz, input longint base,
                            input int head, input int slots);
    drain();
    write_reg(CFG_SIDE, 48'(side));
    write_reg(CFG_TICK, 48'(tsz));
    write_reg(CFG_BASE, base[47:0]);
    write_reg(CFG_HEAD, 48'(head));
    write_reg(CFG_SLOTS, 48'(slots));
    cfg_valid_i <= 1'b0;
    cur_tick = tsz; cur_base = base; cur_slots = slots;
  endtask

  // valid stays up after the item; the next call or drain decides what follows
  task automatic send_item(input kind_e kind, input logic [47:0] price, input logic empty);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= kind;
    s_data  <= {7'b0, empty, price};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
  endtask

  // price that lands near or inside the ladder for the current setting
  function automatic logic [47:0] ladder_price();
    longint tk, p;
    int span;
    span = (cur_slots > 1024 ? 1024 : cur_slots) + 4;
    tk = cur_base + longint'($urandom_range(span)) - 2;
    p = (cur_tick == 0) ? tk : tk * longint'(cur_tick);
    if (cur_tick > 1 && $urandom_range(1))
      p += (tk < 0 ? -1 : 1) * longint'($urandom_range(cur_tick - 1));
    return p[47:0];
  endfunction

  task automatic random_items(input int count);
    logic [47:0] p;
    for (int i = 0; i < count; i++) begin
      p = ($urandom_range(9) == 0) ? 48'({$urandom, $urandom}) : ladder_price();
      send_item(kind_e'($urandom_range(3)), p, $urandom_range(3) != 0);
    end
  endtask

  initial begin
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cur_tick = 20'd1; cur_base = 0; cur_slots = 1024;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset setting, empty ladder, extremes of price and slots
    send_item(KIND_BEST, '0, 1'b0);                  // nothing active
    send_item(KIND_LOOKUP, 48'd5, 1'b0);             // lookup of inactive level
    send_item(KIND_ACTIVATE, 48'd0, 1'b0);           // head slot
    send_item(KIND_ACTIVATE, 48'd1023, 1'b0);        // top slot
    send_item(KIND_BEST, '0, 1'b0);                  // buy: highest
    send_item(KIND_ACTIVATE, 48'd1024, 1'b0);        // just past the ladder
    send_item(KIND_ACTIVATE, 48'hFFFF_FFFF_FFFF, 1'b0); // -1, below base
    send_item(KIND_LOOKUP, 48'h8000_0000_0000, 1'b1); // most negative price
    send_item(KIND_LOOKUP, 48'h7FFF_FFFF_FFFF, 1'b1); // most positive price
    send_item(KIND_REMOVE, 48'd1023, 1'b0);          // not empty: kept
    send_item(KIND_LOOKUP, 48'd1023, 1'b0);
    send_item(KIND_REMOVE, 48'd1023, 1'b1);          // empty: cleared
    send_item(KIND_BEST, '0, 1'b1);
    // sell side, wrapped head beyond slots, tick division with negative prices
    set_ladder(1'b1, 20'd7, -48'sd20, 900, 100);
    send_item(KIND_ACTIVATE, -48'sd69, 1'b0);        // -69/7 = -9 truncates toward zero
    send_item(KIND_ACTIVATE, -48'sd140, 1'b0);       // base tick
    send_item(KIND_BEST, '0, 1'b0);
    send_item(KIND_ACTIVATE, 48'd553, 1'b0);         // 79: last slot
    // disabled ladder
    set_ladder(1'b0, 20'd0, 0, 0, 0);
    send_item(KIND_ACTIVATE, 48'd0, 1'b0);
    send_item(KIND_BEST, '0, 1'b0);
    // oversized slot count, largest tick size, wrapping ladder tick
    set_ladder(1'b0, 20'hFFFFF, 48'sh7FFF_FFFF_FF00, 1023, 2047);
    send_item(KIND_ACTIVATE, 48'h7FFF_FFFF_FFFF, 1'b0);
    send_item(KIND_BEST, '0, 1'b0);
    set_ladder(1'b0, 20'd0, 48'sh7FFF_FFFF_FF00, 1023, 2047);
    send_item(KIND_ACTIVATE, 48'h8000_0000_0010, 1'b0); // out of range
    send_item(KIND_ACTIVATE, 48'h7FFF_FFFF_FFFF, 1'b0);
    send_item(KIND_BEST, '0, 1'b0);

    // random phases: each with its own ladder setting and idling pattern
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      drain();
      recv_stall_pct = 0;
      set_ladder(1'($urandom_range(1)),
                 (ph == 3) ? 20'd0 : 20'($urandom_range(ph < 4 ? 20 : 1048575)),
                 longint'(signed'(48'({$urandom, $urandom}))) >>> $urandom_range(47),
                 int'($urandom_range(1023)), (ph == 5) ? 1 : (ph < 2 ?
                 int'($urandom_range(64)) : int'($urandom_range(2047))));
      case (ph % 4)
        2: recv_stall_pct = 87;
        3: recv_stall_pct = 35;
        default: recv_stall_pct = 0;
      endcase
      random_items(250);
    end

    recv_stall_pct = 0;
    drain();
    $display("covered %0d results over 8 random phases with sell/buy, scaling, wrap", results);
    $display("and disabled, oversized and single-slot ladders");
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: filelist.f
hdl/plb_pkg.sv
hdl/plb_div.sv
hdl/plb_bitmap_ram.sv
hdl/price_ladder_bitmap_best_level.sv
sim/price_ladder_bitmap_best_level_checker.sv
sim/price_ladder_bitmap_best_level_test.sv
